// ----- src/mtq_pkg.sv -----
// shared types and constants for the matrix to quaternion converter
package mtq_pkg;

  localparam int unsigned DW   = 32;          // data width
  localparam int unsigned FB   = DW - 2;      // fraction bits
  localparam int unsigned AW   = DW + 2;      // root argument width
  localparam int unsigned RADW = AW + FB;     // radicand width
  localparam int unsigned SH   = DW - FB + 1; // numerator magnitude bits that go into the low word
  localparam int unsigned NL   = 3;           // divider lanes

  typedef struct packed {
    logic signed [DW-1:0] m00;
    logic signed [DW-1:0] m01;
    logic signed [DW-1:0] m02;
    logic signed [DW-1:0] m10;
    logic signed [DW-1:0] m11;
    logic signed [DW-1:0] m12;
    logic signed [DW-1:0] m20;
    logic signed [DW-1:0] m21;
    logic signed [DW-1:0] m22;
  } in_t;

  typedef struct packed {
    logic signed [DW-1:0] qw;
    logic signed [DW-1:0] qx;
    logic signed [DW-1:0] qy;
    logic signed [DW-1:0] qz;
    logic                 bad_input;
  } out_t;

  // one divider lane: partial remainder, dividend bits still to shift in, quotient
  typedef struct packed {
    logic [DW-1:0] rem;
    logic [DW-1:0] low;
    logic [DW-1:0] quo;
    logic          ovf;
    logic          neg;
  } lane_t;

  typedef struct packed {
    logic                bad;
    logic [1:0]          diag;
    lane_t [NL-1:0]      lanes;
  } side_t;

endpackage

// ----- src/mtq_front.sv -----
// input stage: trace, pivot choice, root argument and numerators
module mtq_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  mtq_pkg::in_t               data_i,
  output logic                       valid_o,
  output logic [mtq_pkg::RADW-1:0]   rad_o,
  output mtq_pkg::side_t             side_o
);
  import mtq_pkg::*;

  logic                 valid_q;
  logic [RADW-1:0]      rad_q, rad_d;
  side_t                side_q, side_d;

  logic signed [AW-1:0] d0, d1, d2, trace, arg, one;
  logic signed [DW:0]   n [NL];
  logic [DW:0]          mag;
  logic [1:0]           piv;

  function automatic logic signed [DW:0] ext1(input logic signed [DW-1:0] a);
    return {a[DW-1], a};
  endfunction

  always_comb begin
    d0    = {{2{data_i.m00[DW-1]}}, data_i.m00};
    d1    = {{2{data_i.m11[DW-1]}}, data_i.m11};
    d2    = {{2{data_i.m22[DW-1]}}, data_i.m22};
    one   = AW'(1) << FB;
    trace = d0 + d1 + d2;
    piv   = 2'd0;
    if (data_i.m11 > data_i.m00) piv = 2'd1;
    if (piv == 2'd1) begin
      if (data_i.m22 > data_i.m11) piv = 2'd2;
    end else begin
      if (data_i.m22 > data_i.m00) piv = 2'd2;
    end
    side_d     = '0;
    side_d.bad = 1'b0;
    if (trace > 0) begin
      arg         = trace + one;
      side_d.diag = 2'd0;
      n[0] = ext1(data_i.m21) - ext1(data_i.m12);
      n[1] = ext1(data_i.m02) - ext1(data_i.m20);
      n[2] = ext1(data_i.m10) - ext1(data_i.m01);
    end else begin
      unique case (piv)
        2'd1: begin
          arg  = d1 - d2 - d0 + one;
          n[0] = ext1(data_i.m02) - ext1(data_i.m20);
          n[1] = ext1(data_i.m01) + ext1(data_i.m10);
          n[2] = ext1(data_i.m21) + ext1(data_i.m12);
        end
        2'd2: begin
          arg  = d2 - d0 - d1 + one;
          n[0] = ext1(data_i.m10) - ext1(data_i.m01);
          n[1] = ext1(data_i.m02) + ext1(data_i.m20);
          n[2] = ext1(data_i.m12) + ext1(data_i.m21);
        end
        default: begin
          arg  = d0 - d1 - d2 + one;
          n[0] = ext1(data_i.m21) - ext1(data_i.m12);
          n[1] = ext1(data_i.m10) + ext1(data_i.m01);
          n[2] = ext1(data_i.m20) + ext1(data_i.m02);
        end
      endcase
      side_d.diag = piv + 2'd1;
      side_d.bad  = (arg <= 0);
    end
    rad_d = {arg, {FB{1'b0}}};
    for (int l = 0; l < NL; l++) begin
      mag = n[l][DW] ? (DW+1)'(-n[l]) : n[l];
      side_d.lanes[l].neg = n[l][DW];
      // dividend is mag shifted up by FB-1, split into high remainder and low word
      side_d.lanes[l].rem = DW'(mag[DW:SH]);
      side_d.lanes[l].low = {mag[SH-1:0], {(DW-SH){1'b0}}};
      side_d.lanes[l].quo = '0;
      side_d.lanes[l].ovf = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_d;
      side_q <= side_d;
    end
  end

  assign valid_o = valid_q;
  assign rad_o   = rad_q;
  assign side_o  = side_q;

endmodule

// ----- src/mtq_sqrt_cell.sv -----
// one square root cell: settles one root bit per stage
module mtq_sqrt_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [mtq_pkg::RADW-1:0] rad_i,
  input  logic [mtq_pkg::DW:0]     rem_i,
  input  logic [mtq_pkg::DW-1:0]   root_i,
  input  mtq_pkg::side_t           side_i,
  output logic                     valid_o,
  output logic [mtq_pkg::RADW-1:0] rad_o,
  output logic [mtq_pkg::DW:0]     rem_o,
  output logic [mtq_pkg::DW-1:0]   root_o,
  output mtq_pkg::side_t           side_o
);
  import mtq_pkg::*;

  logic            valid_q;
  logic [RADW-1:0] rad_q;
  logic [DW:0]     rem_q, rem_d;
  logic [DW-1:0]   root_q, root_d;
  side_t           side_q;
  logic [DW+2:0]   sh, trial;

  always_comb begin
    sh    = {rem_i, rad_i[RADW-1 -: 2]};
    trial = {1'b0, root_i, 2'b01};
    if (sh >= trial) begin
      rem_d  = (DW+1)'(sh - trial);
      root_d = {root_i[DW-2:0], 1'b1};
    end else begin
      rem_d  = sh[DW:0];
      root_d = {root_i[DW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= {rad_i[RADW-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rad_o   = rad_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign side_o  = side_q;

endmodule

// ----- src/mtq_div_cell.sv -----
// one divider cell: one quotient bit per stage in each of the lanes
module mtq_div_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [mtq_pkg::DW-1:0] root_i,
  input  mtq_pkg::side_t         side_i,
  output logic                   valid_o,
  output logic [mtq_pkg::DW-1:0] root_o,
  output mtq_pkg::side_t         side_o
);
  import mtq_pkg::*;

  logic          valid_q;
  logic [DW-1:0] root_q;
  side_t         side_q, side_d;
  logic [DW:0]   sh;

  always_comb begin
    side_d = side_i;
    for (int l = 0; l < NL; l++) begin
      sh = {side_i.lanes[l].rem, side_i.lanes[l].low[DW-1]};
      // a remainder at or above the divisor means the quotient does not fit
      side_d.lanes[l].ovf = side_i.lanes[l].ovf | (side_i.lanes[l].rem >= root_i);
      side_d.lanes[l].low = {side_i.lanes[l].low[DW-2:0], 1'b0};
      if (sh >= {1'b0, root_i}) begin
        side_d.lanes[l].rem = DW'(sh - {1'b0, root_i});
        side_d.lanes[l].quo = {side_i.lanes[l].quo[DW-2:0], 1'b1};
      end else begin
        side_d.lanes[l].rem = sh[DW-1:0];
        side_d.lanes[l].quo = {side_i.lanes[l].quo[DW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      root_q <= root_i;
      side_q <= side_d;
    end
  end

  assign valid_o = valid_q;
  assign root_o  = root_q;
  assign side_o  = side_q;

endmodule

// ----- src/matrix_to_quaternion_top.sv -----
// matrix to quaternion converter: front stage, square root chain, divider chain, output
// an input transaction passes the front register, the root cells, the divider cells and the output register
// throughput: one matrix per cycle; a chain of one-bit root cells then one-bit divider cells
// the whole pipe advances together and holds only while a result waits unaccepted
// reset: asynchronous active low, clears all valid flags; no state survives between items
module matrix_to_quaternion_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  mtq_pkg::in_t    in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output mtq_pkg::out_t   out_data_o
);
  import mtq_pkg::*;

  logic en;

  logic            sv [DW+1];
  logic [RADW-1:0] srad [DW+1];
  logic [DW:0]     srem [DW+1];
  logic [DW-1:0]   sroot [DW+1];
  side_t           sside [DW+1];

  logic            dv [DW+1];
  logic [DW-1:0]   droot [DW+1];
  side_t           dside [DW+1];

  logic            out_valid_q;
  out_t            out_q, out_d;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  mtq_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (sv[0]),
    .rad_o   (srad[0]),
    .side_o  (sside[0])
  );

  assign srem[0]  = '0;
  assign sroot[0] = '0;

  for (genvar g = 0; g < DW; g++) begin : g_sqrt
    mtq_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sv[g]),
      .rad_i   (srad[g]),
      .rem_i   (srem[g]),
      .root_i  (sroot[g]),
      .side_i  (sside[g]),
      .valid_o (sv[g+1]),
      .rad_o   (srad[g+1]),
      .rem_o   (srem[g+1]),
      .root_o  (sroot[g+1]),
      .side_o  (sside[g+1])
    );
  end

  assign dv[0]    = sv[DW];
  assign droot[0] = sroot[DW];
  assign dside[0] = sside[DW];

  for (genvar g = 0; g < DW; g++) begin : g_div
    mtq_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv[g]),
      .root_i  (droot[g]),
      .side_i  (dside[g]),
      .valid_o (dv[g+1]),
      .root_o  (droot[g+1]),
      .side_o  (dside[g+1])
    );
  end

  // place the diagonal term and the three quotients into their slots, then saturate; bad input gives all zeros
  logic [DW-1:0] res [4];
  logic [1:0]    li;
  lane_t         ln;

  always_comb begin
    for (int s = 0; s < 4; s++) begin
      li = (2'(s) < dside[DW].diag) ? 2'(s) : 2'(s - 1);
      ln = dside[DW].lanes[li];
      if (dside[DW].bad) begin
        res[s] = '0;
      end else if (2'(s) == dside[DW].diag) begin
        res[s] = {1'b0, droot[DW][DW-1:1]};
      end else if (!ln.neg) begin
        res[s] = (ln.ovf || ln.quo[DW-1]) ? {1'b0, {(DW-1){1'b1}}} : ln.quo;
      end else begin
        res[s] = (ln.ovf || (ln.quo[DW-1] && |ln.quo[DW-2:0]))
               ? {1'b1, {(DW-1){1'b0}}} : DW'(-ln.quo);
      end
    end
    out_d.qw        = res[0];
    out_d.qx        = res[1];
    out_d.qy        = res[2];
    out_d.qz        = res[3];
    out_d.bad_input = dside[DW].bad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv[DW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
